[hdl/spsr_pkg.sv]
package spsr_pkg;

   // field and state widths
   localparam int unsigned PulseW    = 11;
   localparam int unsigned TimeW     = 32;
   localparam int unsigned SpeedW    = 8;
   localparam int unsigned IntervalW = 16;
   localparam int unsigned DeltaW    = 9;

   typedef logic [PulseW-1:0]    pulse_type;
   typedef logic [TimeW-1:0]     time_type;
   typedef logic [SpeedW-1:0]    speed_type;
   typedef logic [IntervalW-1:0] interval_type;
   typedef logic [DeltaW-1:0]    delta_type;
   typedef logic signed [1:0]    dir_type;

   // pulse limits in microseconds
   localparam pulse_type PULSE_NEUTRAL = 11'd1500;
   localparam pulse_type PULSE_MAX     = 11'd2000;
   localparam pulse_type PULSE_MIN     = 11'd1000;

   // full-scale speed, also the divisor of the speed-to-delta scaling
   localparam speed_type SPEED_FULL = 8'd255;

   localparam interval_type INTERVAL_RESET = 16'd10;

   // direction codes
   localparam dir_type DIR_NONE    = 2'sb00;
   localparam dir_type DIR_FORWARD = 2'sb01;
   localparam dir_type DIR_REVERSE = 2'sb11;

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type   cmd;
      time_type  now_ms;
      dir_type   direction;
      speed_type speed_level;
   } item_type;

   typedef struct packed {
      pulse_type pulse_us;
      logic      pulse_written;
      logic      ramp_done;
   } result_type;

endpackage

[hdl/spsr_ifs.sv]
// request channel: one command beat
interface spsr_req_if;
   import spsr_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   cmd;
   time_type  now_ms;
   dir_type   direction;
   speed_type speed_level;

   modport source (output valid, output cmd, output now_ms, output direction,
                   output speed_level, input ready);
   modport sink   (input valid, input cmd, input now_ms, input direction,
                   input speed_level, output ready);
endinterface

// response channel: one result beat
interface spsr_rsp_if;
   import spsr_pkg::*;

   logic      valid;
   logic      ready;
   pulse_type pulse_us;
   logic      pulse_written;
   logic      ramp_done;

   modport source (output valid, output pulse_us, output pulse_written,
                   output ramp_done, input ready);
   modport sink   (input valid, input pulse_us, input pulse_written,
                   input ramp_done, output ready);
endinterface

[hdl/spsr_scale.sv]
// delta = floor(500 * speed / 255), reciprocal multiply plus one correction
module spsr_scale (
   input  spsr_pkg::speed_type speed,
   output spsr_pkg::delta_type delta
);
   import spsr_pkg::*;

   logic [16:0] span_prod;
   logic [24:0] recip_prod;
   delta_type   quot_est;
   logic [17:0] quot_x255;
   logic [17:0] remainder;

   // 500 * speed as shift-and-subtract (500 = 512 - 8 - 4)
   assign span_prod = {speed, 9'b0} - 17'({speed, 3'b0}) - 17'({speed, 2'b0});

   // x * 257 / 65536 never overshoots and is low by at most one
   assign recip_prod = {span_prod, 8'b0} + {8'b0, span_prod};
   assign quot_est   = recip_prod[24:16];

   // remainder check against the divisor
   assign quot_x255 = {1'b0, quot_est, 8'b0} - {9'b0, quot_est};
   assign remainder = {1'b0, span_prod} - quot_x255;
   assign delta     = (remainder >= 18'(SPEED_FULL)) ? quot_est + 1'b1 : quot_est;

endmodule

[hdl/spsr_core.sv]
// ramp state and the per-beat update; result is combinational
module spsr_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  spsr_pkg::item_type     item,
   input  logic                   csr_wr_en,
   input  spsr_pkg::interval_type csr_wr_data,
   output spsr_pkg::result_type   result
);
   import spsr_pkg::*;

   interval_type interval_ff;
   pulse_type    pulse_ff,      pulse_in;
   pulse_type    target_ff,     target_in;
   speed_type    held_speed_ff, held_speed_in;
   dir_type      held_dir_ff,   held_dir_in;
   time_type     last_start_ff, last_start_in;
   time_type     last_stop_ff,  last_stop_in;

   delta_type delta;
   time_type  since_start;
   time_type  since_stop;
   logic      start_due;
   logic      stop_due;
   logic      written;
   logic      done;

   function automatic pulse_type step_toward(pulse_type cur, pulse_type goal);
      pulse_type nxt;
      nxt = cur;
      if (cur > goal) begin
         nxt = cur - 1'b1;
      end else if (cur < goal) begin
         nxt = cur + 1'b1;
      end
      return nxt;
   endfunction

   function automatic pulse_type clamp_pulse(pulse_type val);
      pulse_type res;
      res = val;
      if (val >= PULSE_MAX) begin
         res = PULSE_MAX;
      end else if (val <= PULSE_MIN) begin
         res = PULSE_MIN;
      end
      return res;
   endfunction

   spsr_scale u_scale (
      .speed (item.speed_level),
      .delta (delta)
   );

   // modular elapsed time since each kind's last step
   assign since_start = item.now_ms - last_start_ff;
   assign since_stop  = item.now_ms - last_stop_ff;
   assign start_due   = since_start >= TimeW'(interval_ff);
   assign stop_due    = since_stop >= TimeW'(interval_ff);

   // next state for the beat at the input register
   always_comb begin
      pulse_in      = pulse_ff;
      target_in     = target_ff;
      held_speed_in = held_speed_ff;
      held_dir_in   = held_dir_ff;
      last_start_in = last_start_ff;
      last_stop_in  = last_stop_ff;
      written       = 1'b0;
      done          = 1'b1;
      case (item.cmd)
         CMD_SET: begin
            // an unchanged pair leaves everything alone
            if (!(item.direction == held_dir_ff && item.speed_level == held_speed_ff)) begin
               held_speed_in = item.speed_level;
               if (item.direction == DIR_REVERSE) begin
                  held_dir_in = DIR_REVERSE;
                  target_in   = PULSE_NEUTRAL - PulseW'(delta);
               end else if (item.direction == DIR_FORWARD) begin
                  held_dir_in = DIR_FORWARD;
                  target_in   = PULSE_NEUTRAL + PulseW'(delta);
               end
            end
         end
         CMD_START: begin
            if (pulse_ff != target_ff) begin
               done = 1'b0;
               if (start_due) begin
                  last_start_in = item.now_ms;
                  written       = 1'b1;
                  // with no direction ever set the pulse is rewritten as is
                  if (held_dir_ff == DIR_FORWARD || held_dir_ff == DIR_REVERSE) begin
                     pulse_in = clamp_pulse(step_toward(pulse_ff, target_ff));
                  end else begin
                     pulse_in = clamp_pulse(pulse_ff);
                  end
               end
            end
         end
         CMD_STOP: begin
            if (pulse_ff != PULSE_NEUTRAL && stop_due) begin
               last_stop_in = item.now_ms;
               written      = 1'b1;
               pulse_in     = clamp_pulse(step_toward(pulse_ff, PULSE_NEUTRAL));
            end
         end
         default: begin
         end
      endcase
   end

   assign result.pulse_us      = pulse_in;
   assign result.pulse_written = written;
   assign result.ramp_done     = done;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff      <= PULSE_NEUTRAL;
         target_ff     <= PULSE_NEUTRAL;
         held_speed_ff <= '0;
         held_dir_ff   <= DIR_NONE;
         last_start_ff <= '0;
         last_stop_ff  <= '0;
      end else if (step_en) begin
         pulse_ff      <= pulse_in;
         target_ff     <= target_in;
         held_speed_ff <= held_speed_in;
         held_dir_ff   <= held_dir_in;
         last_start_ff <= last_start_in;
         last_stop_ff  <= last_stop_in;
      end
   end

   // interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   // pulse stays inside the legal window
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      pulse_ff >= PULSE_MIN && pulse_ff <= PULSE_MAX)
      else $error("pulse width out of range");

   // only start and stop beats move the pulse, by at most one
   a_pulse_only_ramp: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd != CMD_START && item.cmd != CMD_STOP |=> $stable(pulse_ff))
      else $error("pulse moved on a non-ramp beat");

   // the held direction is never the unused code
   a_dir_legal: assert property (@(posedge clock) disable iff (reset)
      held_dir_ff == DIR_NONE || held_dir_ff == DIR_FORWARD || held_dir_ff == DIR_REVERSE)
      else $error("held direction corrupted");

   // a beat that reports no write leaves the timestamps alone
   a_no_write_no_stamp: assert property (@(posedge clock) disable iff (reset)
      step_en && !written |=> $stable(last_start_ff) && $stable(last_stop_ff))
      else $error("timestamp moved without a pulse write");

endmodule

[hdl/servo_pulse_slew_ramp_top.sv]
// Channel   Dir   Beat contents
// req_bus   in    cmd, now_ms, direction, speed_level
// rsp_bus   out   pulse_us, pulse_written, ramp_done
// csr_*     in    ramp_interval_ms write (csr_wr_en, csr_wr_data)
//
// One beat per clock sustained while the response side is ready; a request is
// answered through the input register, then the state update into the result register.
// Reset is synchronous and puts the pulse and target at 1500, interval at 10.
// A stalled response holds in the result register while the input register
// still takes one more beat; the state update runs only as the result
// register is freed.
module servo_pulse_slew_ramp_top (
   input  logic                   clock,
   input  logic                   reset,
   spsr_req_if.sink               req_bus,
   spsr_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  spsr_pkg::interval_type csr_wr_data
);
   import spsr_pkg::*;

   logic       in_valid_ff,  in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   result_type result;
   logic       req_take;
   logic       advance;

   // the input beat moves on whenever the result register is free
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd         <= req_bus.cmd;
         in_item_ff.now_ms      <= req_bus.now_ms;
         in_item_ff.direction   <= req_bus.direction;
         in_item_ff.speed_level <= req_bus.speed_level;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   spsr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_item_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pulse_us      = out_result_ff.pulse_us;
   assign rsp_bus.pulse_written = out_result_ff.pulse_written;
   assign rsp_bus.ramp_done     = out_result_ff.ramp_done;

   // every processed beat lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed beat not presented");

   // a held input beat is not dropped
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending request lost");

   // nothing is taken while a stalled beat still waits in the input register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken over a pending beat");

endmodule
